// ----- sv/sorted_multiset_engine_macros.svh -----
// assertion macros for the sorted multiset engine
`ifndef SORTED_MULTISET_ENGINE_MACROS_SVH
`define SORTED_MULTISET_ENGINE_MACROS_SVH

`ifndef SYNTHESIS
`define SME_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);
`define SME_ASSERT_NXT(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);
`else
`define SME_ASSERT_IMP(lbl, ck, rn, ante, cons, msg)
`define SME_ASSERT_NXT(lbl, ck, rn, ante, cons, msg)
`endif

`endif

// ----- sv/smc_pkg.sv -----
package smc_pkg;

	// operation codes carried in the request mode
	localparam logic [2:0] MODE_INSERT  = 3'd0;
	localparam logic [2:0] MODE_REM_ONE = 3'd1;
	localparam logic [2:0] MODE_REM_ALL = 3'd2;
	localparam logic [2:0] MODE_CLEAR   = 3'd3;
	localparam logic [2:0] MODE_FIND    = 3'd4;

	// result status codes
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_MISSING = 2'd1;
	localparam logic [1:0] ST_FULL    = 2'd2;
	localparam logic [1:0] ST_EMPTY   = 2'd3;

	// cell operations broadcast along the chain
	localparam logic [1:0] OP_HOLD   = 2'd0;
	localparam logic [1:0] OP_INSERT = 2'd1;
	localparam logic [1:0] OP_SHIFT  = 2'd2;

	typedef struct packed {
		logic [1:0]  op;
		logic [31:0] value;
	} cell_ctl_t;

endpackage

// ----- sv/smc_cell.sv -----
module smc_cell (
	input  logic              clk,
	input  smc_pkg::cell_ctl_t ctl,
	input  logic              occupied,
	input  logic [31:0]       left_val,
	input  logic              left_big,
	input  logic [31:0]       right_val,
	output logic [31:0]       val,
	output logic              big,
	output logic              eq
);

	logic [31:0] val_q;
	logic        ge;

	// compare against the broadcast value; empty cells rank above everything
	assign big = !occupied || ($signed(val_q) > $signed(ctl.value));
	assign ge  = $signed(val_q) >= $signed(ctl.value);
	assign eq  = occupied && (val_q == ctl.value);
	assign val = val_q;

	// insert opens a gap at the first larger cell, shift closes one at the match
	always_ff @(posedge clk) begin
		unique case (ctl.op)
			smc_pkg::OP_INSERT: begin
				if (left_big) begin
					val_q <= left_val;
				end else if (big) begin
					val_q <= ctl.value;
				end
			end
			smc_pkg::OP_SHIFT: begin
				if (ge) begin
					val_q <= right_val;
				end
			end
			default: begin
				val_q <= val_q;
			end
		endcase
	end

endmodule

// ----- sv/sorted_multiset_engine.sv -----
// sorted multiset engine: keeps up to CAPACITY signed 32-bit values in
// ascending order in a chain of cells, each cell comparing its value with
// the request value and trading data with its neighbors.
// input channel s_*: tuser carries the mode (insert, remove one, remove
// each, clear, find), tdata the value. a request is taken only while the
// sequencer is idle.
// output channel m_*: one result per request with found, status, entry
// count, smallest and largest stored value.
// a request passes the accept, execute and result steps of the sequencer;
// remove each stays in the execute step until every occurrence is gone,
// since the chain closes one gap per cycle. a new request is taken only
// after the previous one has passed its execute and result steps.
// the output register parts both sides: a new request is accepted while a
// result waits; a stalled receiver holds the next result in the result
// step until the register frees.
// reset clears the entry count, the sequencer and the output valid; cell
// contents are not cleared and are only read below the entry count.
`include "sorted_multiset_engine_macros.svh"

module sorted_multiset_engine #(
	parameter int CAPACITY = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // value[31:0]
	input  logic [2:0]  s_tuser,   // mode[2:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata,   // entry_count[4:0], smallest[36:5], largest[68:37], zero pad
	output logic [2:0]  m_tuser    // found[0], status[2:1]
);

	localparam int CNT_W = $clog2(CAPACITY + 1);

	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_EXEC   = 2'd1;
	localparam logic [1:0] S_RESULT = 2'd2;

	logic [1:0]       state_q;
	logic [CNT_W-1:0] cnt_q;
	logic [2:0]       mode_q;
	logic [31:0]      value_q;
	logic             first_q;
	logic             found_q;
	logic [1:0]       status_q;

	logic             m_tvalid_q;
	logic [71:0]      m_tdata_q;
	logic [2:0]       m_tuser_q;

	smc_pkg::cell_ctl_t ctl;
	logic [31:0]        cell_val [CAPACITY];
	logic [CAPACITY-1:0] cell_big;
	logic [CAPACITY-1:0] cell_eq;

	logic             any_eq;
	logic             empty;
	logic             full;
	logic [1:0]       exec_status;
	logic [CNT_W-1:0] exec_cnt;
	logic             exec_stay;
	logic [31:0]      largest;
	logic [31:0]      smallest;
	logic             out_free;

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;
	assign out_free = !m_tvalid_q || m_tready;

	assign any_eq = |cell_eq;
	assign empty  = (cnt_q == '0);
	assign full   = (cnt_q == CNT_W'(CAPACITY));

	// chain of cells
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [31:0] lv;
		logic        lb;
		logic [31:0] rv;

		if (i == 0) begin : g_first
			assign lv = cell_val[0];
			assign lb = 1'b0;
		end else begin : g_mid
			assign lv = cell_val[i-1];
			assign lb = cell_big[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign rv = cell_val[i];
		end else begin : g_inner
			assign rv = cell_val[i+1];
		end

		smc_cell u_cell (
			.clk       (clk),
			.ctl       (ctl),
			.occupied  (CNT_W'(i) < cnt_q),
			.left_val  (lv),
			.left_big  (lb),
			.right_val (rv),
			.val       (cell_val[i]),
			.big       (cell_big[i]),
			.eq        (cell_eq[i])
		);
	end

	// execute step: decide cell operation, status and new count
	always_comb begin
		ctl.value   = value_q;
		ctl.op      = smc_pkg::OP_HOLD;
		exec_status = smc_pkg::ST_OK;
		exec_cnt    = cnt_q;
		exec_stay   = 1'b0;
		if (state_q == S_EXEC) begin
			unique case (mode_q)
				smc_pkg::MODE_INSERT: begin
					if (full) begin
						exec_status = smc_pkg::ST_FULL;
					end else begin
						ctl.op   = smc_pkg::OP_INSERT;
						exec_cnt = cnt_q + CNT_W'(1);
					end
				end
				smc_pkg::MODE_REM_ONE, smc_pkg::MODE_REM_ALL: begin
					if (empty) begin
						exec_status = smc_pkg::ST_EMPTY;
					end else if (!any_eq) begin
						exec_status = smc_pkg::ST_MISSING;
					end else begin
						ctl.op    = smc_pkg::OP_SHIFT;
						exec_cnt  = cnt_q - CNT_W'(1);
						exec_stay = (mode_q == smc_pkg::MODE_REM_ALL);
					end
				end
				smc_pkg::MODE_CLEAR: begin
					exec_status = empty ? smc_pkg::ST_EMPTY : smc_pkg::ST_OK;
					exec_cnt    = '0;
				end
				default: begin
					if (empty) begin
						exec_status = smc_pkg::ST_EMPTY;
					end else if (!any_eq) begin
						exec_status = smc_pkg::ST_MISSING;
					end
				end
			endcase
		end
	end

	// smallest and largest from the settled chain
	always_comb begin
		largest = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			if (cnt_q == CNT_W'(i + 1)) begin
				largest = largest | cell_val[i];
			end
		end
		smallest = empty ? 32'd0 : cell_val[0];
	end

	// sequencer and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			first_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						state_q <= S_EXEC;
						first_q <= 1'b1;
					end
				end
				S_EXEC: begin
					cnt_q   <= exec_cnt;
					first_q <= 1'b0;
					if (!exec_stay) begin
						state_q <= S_RESULT;
					end
				end
				S_RESULT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// request capture and first-pass flags
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			mode_q  <= s_tuser;
			value_q <= s_tdata;
		end
		if (state_q == S_EXEC && first_q) begin
			found_q  <= any_eq;
			status_q <= exec_status;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (state_q == S_RESULT && out_free) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_RESULT && out_free) begin
			m_tdata_q <= {3'd0, largest, smallest, 5'(cnt_q)};
			m_tuser_q <= {status_q, found_q};
		end
	end

	`SME_ASSERT_IMP(a_cnt_bound, clk, arst_n, 1'b1, cnt_q <= CNT_W'(CAPACITY), "count above capacity")
	`SME_ASSERT_NXT(a_accept_exec, clk, arst_n, s_tvalid && s_tready, state_q == S_EXEC, "accept did not start execute")
	`SME_ASSERT_NXT(a_insert_cnt, clk, arst_n, state_q == S_EXEC && mode_q == smc_pkg::MODE_INSERT && !full, cnt_q == $past(cnt_q) + CNT_W'(1), "insert did not grow count")
	`SME_ASSERT_IMP(a_sorted_head, clk, arst_n, cnt_q >= CNT_W'(2), $signed(cell_val[0]) <= $signed(cell_val[1]), "store out of order")

endmodule

// ----- dv/tb_sorted_multiset_engine.sv -----
module tb_sorted_multiset_engine;

	localparam int SLOTS        = 16;
	localparam int RANDOM_ITEMS = 1600;
	localparam int LONG_HOLD    = 200;
	localparam int HOLD_AFTER   = 300;
	localparam int PAUSE_EVERY  = 400;
	localparam int SETTLE       = 40;
	localparam int CYCLE_LIMIT  = 400000;

	// traffic profiles for the random part
	localparam int PROF_FILL  = 0;
	localparam int PROF_DRAIN = 1;
	localparam int PROF_MIXED = 2;

	localparam logic signed [31:0] INT_MIN = 32'sh8000_0000;
	localparam logic signed [31:0] INT_MAX = 32'sh7fff_ffff;

	typedef struct {
		logic               found;
		logic [1:0]         status;
		logic [4:0]         count;
		logic signed [31:0] smallest;
		logic signed [31:0] largest;
	} outcome_t;

	// mirrors the sorted store and queues the outcome of every request
	class multiset_tracker;
		logic signed [31:0] store[$];
		outcome_t           due[$];
		int                 errors;

		function new();
			errors = 0;
		endfunction

		function int pending();
			return due.size();
		endfunction

		function void note_request(logic [2:0] mode, logic signed [31:0] value);
			outcome_t o;
			bit       was;
			int       n;
			int       pos;
			was = 0;
			foreach (store[i])
				if (store[i] == value) was = 1;
			n = store.size();
			o.status = smc_pkg::ST_OK;
			case (mode)
				smc_pkg::MODE_INSERT: begin
					if (n >= SLOTS) begin
						o.status = smc_pkg::ST_FULL;
					end else begin
						// new value lands after any equal values
						pos = 0;
						while (pos < n && store[pos] <= value) pos++;
						store.insert(pos, value);
					end
				end
				smc_pkg::MODE_REM_ONE, smc_pkg::MODE_REM_ALL: begin
					if (n == 0) begin
						o.status = smc_pkg::ST_EMPTY;
					end else if (!was) begin
						o.status = smc_pkg::ST_MISSING;
					end else if (mode == smc_pkg::MODE_REM_ONE) begin
						pos = 0;
						while (store[pos] != value) pos++;
						store.delete(pos);
					end else begin
						for (int i = n - 1; i >= 0; i--)
							if (store[i] == value) store.delete(i);
					end
				end
				smc_pkg::MODE_CLEAR: begin
					o.status = (n == 0) ? smc_pkg::ST_EMPTY : smc_pkg::ST_OK;
					store.delete();
				end
				// find, and the unused codes that behave like it
				default: begin
					if (n == 0) o.status = smc_pkg::ST_EMPTY;
					else if (!was) o.status = smc_pkg::ST_MISSING;
				end
			endcase
			o.found    = was;
			o.count    = 5'(store.size());
			o.smallest = (store.size() == 0) ? 32'sd0 : store[0];
			o.largest  = (store.size() == 0) ? 32'sd0 : store[store.size() - 1];
			due.push_back(o);
		endfunction

		function void flag(string what, logic signed [31:0] want, logic signed [31:0] seen);
			if (seen !== want) begin
				$display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, seen);
				errors++;
			end
		endfunction

		function void check_result(outcome_t got);
			outcome_t want;
			if (due.size() == 0) begin
				$display("%0t: result with no request pending, found %0d status %0d count %0d",
					$time, got.found, got.status, got.count);
				errors++;
				return;
			end
			want = due.pop_front();
			flag("found", {31'd0, want.found}, {31'd0, got.found});
			flag("status", {30'd0, want.status}, {30'd0, got.status});
			flag("entry_count", {27'd0, want.count}, {27'd0, got.count});
			flag("smallest", want.smallest, got.smallest);
			flag("largest", want.largest, got.largest);
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;
	logic [2:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [71:0] m_tdata;
	logic [2:0]  m_tuser;

	multiset_tracker    tracker = new();
	bit                 send_fast;
	logic signed [31:0] value_pool[6];
	int                 cycles = 0;

	sorted_multiset_engine #(
		.CAPACITY(SLOTS)
	) i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser)
	);

	// clock
	initial clk = 1'b0;
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// result monitor
	always @(posedge clk) begin
		outcome_t got;
		if (arst_n && m_tvalid && m_tready) begin
			got.found    = m_tuser[0];
			got.status   = m_tuser[2:1];
			got.count    = m_tdata[4:0];
			got.smallest = m_tdata[36:5];
			got.largest  = m_tdata[68:37];
			tracker.check_result(got);
		end
	end

	// receiver: random stalls, runs of no stall, one long hold-off
	initial begin
		int  gap;
		int  taken;
		bit  held;
		bit  recv_fast;
		m_tready = 1'b0;
		taken    = 0;
		held     = 0;
		recv_fast = 0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (taken % 50 == 0) recv_fast = ($urandom_range(0, 3) == 0);
			if (!held && taken >= HOLD_AFTER) begin
				held = 1;
				gap  = LONG_HOLD;
			end else begin
				gap = recv_fast ? 0 : $urandom_range(0, 12);
			end
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid) @(posedge clk);
			taken++;
			@(negedge clk);
		end
	end

	// offer one request and wait for it to be taken
	task automatic send_request(input logic [2:0] mode, input logic signed [31:0] value);
		int gap;
		gap = send_fast ? 0 : $urandom_range(0, 12);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= mode;
		s_tdata  <= value;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		tracker.note_request(mode, value);
		@(negedge clk);
	endtask

	// stop offering until every request has its result
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		do @(negedge clk); while (tracker.pending() != 0);
	endtask

	function automatic logic [2:0] pick_mode(int profile);
		int r;
		r = $urandom_range(0, 99);
		case (profile)
			PROF_FILL: begin
				if (r < 75) return smc_pkg::MODE_INSERT;
				if (r < 85) return smc_pkg::MODE_FIND;
				if (r < 92) return smc_pkg::MODE_REM_ONE;
				if (r < 97) return smc_pkg::MODE_REM_ALL;
				if (r < 99) return 3'($urandom_range(5, 7));
				return smc_pkg::MODE_CLEAR;
			end
			PROF_DRAIN: begin
				if (r < 15) return smc_pkg::MODE_INSERT;
				if (r < 30) return smc_pkg::MODE_FIND;
				if (r < 65) return smc_pkg::MODE_REM_ONE;
				if (r < 90) return smc_pkg::MODE_REM_ALL;
				if (r < 95) return 3'($urandom_range(5, 7));
				return smc_pkg::MODE_CLEAR;
			end
			default: begin
				if (r < 40) return smc_pkg::MODE_INSERT;
				if (r < 55) return smc_pkg::MODE_FIND;
				if (r < 72) return smc_pkg::MODE_REM_ONE;
				if (r < 85) return smc_pkg::MODE_REM_ALL;
				if (r < 93) return 3'($urandom_range(5, 7));
				return smc_pkg::MODE_CLEAR;
			end
		endcase
	endfunction

	// mostly values from a small pool so that hits and duplicates are common
	function automatic logic signed [31:0] pick_value();
		if ($urandom_range(0, 99) < 80) return value_pool[$urandom_range(0, 5)];
		return $urandom;
	endfunction

	task automatic refill_pool();
		int r;
		foreach (value_pool[i]) begin
			r = $urandom_range(0, 5);
			if (r < 2) value_pool[i] = $signed($urandom_range(0, 8)) - 32'sd4;
			else if (r == 2) value_pool[i] = $urandom_range(0, 1) ? INT_MIN : INT_MAX;
			else value_pool[i] = $urandom;
		end
	endtask

	// stimulus
	initial begin
		int sent;
		int seg_len;
		int profile;
		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tuser   = smc_pkg::MODE_FIND;
		send_fast = 0;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// empty store corner cases
		send_request(smc_pkg::MODE_FIND, 32'sd5);
		send_request(smc_pkg::MODE_REM_ONE, 32'sd5);
		send_request(smc_pkg::MODE_REM_ALL, 32'sd5);
		send_request(smc_pkg::MODE_CLEAR, 32'sd0);
		// extremes and duplicates
		send_request(smc_pkg::MODE_INSERT, INT_MAX);
		send_request(smc_pkg::MODE_INSERT, INT_MIN);
		send_request(smc_pkg::MODE_INSERT, 32'sd0);
		send_request(smc_pkg::MODE_INSERT, 32'sd0);
		send_request(smc_pkg::MODE_INSERT, -32'sd1);
		send_request(smc_pkg::MODE_FIND, 32'sd0);
		send_request(smc_pkg::MODE_FIND, 32'sd7);
		send_request(smc_pkg::MODE_REM_ONE, 32'sd0);
		send_request(smc_pkg::MODE_REM_ONE, 32'sd123);
		send_request(smc_pkg::MODE_REM_ALL, 32'sd7);
		send_request(smc_pkg::MODE_INSERT, 32'sd0);
		send_request(smc_pkg::MODE_INSERT, 32'sd0);
		send_request(smc_pkg::MODE_REM_ALL, 32'sd0);
		// unused mode codes behave as find
		send_request(3'd5, INT_MAX);
		send_request(3'd6, 32'sd42);
		send_request(3'd7, INT_MIN);
		send_request(smc_pkg::MODE_REM_ALL, INT_MIN);
		send_request(smc_pkg::MODE_REM_ONE, INT_MAX);
		send_request(smc_pkg::MODE_CLEAR, 32'sd0);
		send_request(smc_pkg::MODE_CLEAR, 32'sd0);

		// random segments with fill, drain and mixed profiles
		sent    = 0;
		profile = PROF_FILL;
		while (sent < RANDOM_ITEMS) begin
			seg_len   = $urandom_range(20, 60);
			send_fast = ($urandom_range(0, 3) == 0);
			refill_pool();
			for (int k = 0; k < seg_len && sent < RANDOM_ITEMS; k++) begin
				send_request(pick_mode(profile), pick_value());
				sent++;
				if (sent % PAUSE_EVERY == 0) wait_drained();
			end
			profile = $urandom_range(PROF_FILL, PROF_MIXED);
		end

		// drain and settle
		wait_drained();
		repeat (SETTLE) @(negedge clk);
		if (tracker.errors == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
